FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bwm_pkg.sv
// Package for the weighted-mid book unit: constants, structs, state types.
// No dependencies.
package bwm_pkg;

    localparam int SUBJECTS = 1024;
    localparam int ADDR_W   = (SUBJECTS > 1) ? $clog2(SUBJECTS) : 1;
    localparam int ENTRY_W  = 96;   // {value 64, volume 32}
    localparam int ACC_W    = 98;   // signed numerator sum
    localparam int NUM_W    = 97;   // numerator magnitude
    localparam int DEN_W    = 33;   // volume sum
    localparam int REM_W    = 35;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [3:0] HDR_BYTES  = 4'd10;
    localparam logic [3:0] UPD_LAST   = 4'd13;
    localparam logic [7:0] SIDE_DEMAND = 8'd0;
    localparam logic [7:0] SIDE_SUPPLY = 8'd1;

    typedef struct packed {
        logic              en;
        logic              supply;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       value;
        logic [31:0]       volume;
    } t_wr_req;

    typedef struct packed {
        logic        en;
        logic        has_result;
        logic [31:0] subject;
    } t_msg_end;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WAIT, S_READ, S_LOAD, S_CALC, S_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        C_IDLE, C_MUL, C_PREP, C_DIV, C_DONE
    } t_calc_state;

endpackage

FILE: rtl/core/bwm_ifs.sv
// Valid/ready channel interfaces for the byte input and the result output.
// No dependencies.
interface bwm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       last_byte;
    modport source (output valid, output msg_byte, output last_byte, input ready);
    modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface

interface bwm_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        subject_number;
    logic signed [63:0] weighted_score;
    logic               subject_out_of_table;
    modport source (output valid, output subject_number, output weighted_score,
                    output subject_out_of_table, input ready);
    modport sink   (input valid, input subject_number, input weighted_score,
                    input subject_out_of_table, output ready);
endinterface

FILE: rtl/core/bwm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/bwm_parse.sv
// Byte-stream parser: header, update assembly, level-0 store requests.
// Depends on bwm_pkg.
module bwm_parse import bwm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_wr_req    o_wr,
    output t_msg_end   o_end
);
    logic [3:0]  r_hpos, n_hpos;
    logic [3:0]  r_upos, n_upos;
    logic [31:0] r_subj, n_subj;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_level, n_level;
    logic [7:0]  r_side, n_side;
    logic [63:0] r_value, n_value;
    logic [31:0] r_vol, n_vol;
    logic        r_done, n_done;
    t_wr_req     r_wr, n_wr;
    t_msg_end    r_end, n_end;
    logic [3:0]  v_off;
    logic [3:0]  v_voff;

    always_comb begin
        n_hpos = r_hpos; n_upos = r_upos; n_subj = r_subj; n_cnt = r_cnt;
        n_level = r_level; n_side = r_side; n_value = r_value; n_vol = r_vol;
        n_done = r_done;
        n_wr = '0;
        n_end = '0;
        v_off = 4'(r_upos - 4'd2);
        v_voff = 4'(r_upos - 4'd10);
        if (i_accept) begin
            if (r_hpos < HDR_BYTES) begin
                if (r_hpos >= 4'd4 && r_hpos < 4'd8) begin
                    n_subj[8*r_hpos[1:0] +: 8] = i_byte;
                end else if (r_hpos >= 4'd8) begin
                    n_cnt[8*r_hpos[0] +: 8] = i_byte;
                end
                n_hpos = 4'(r_hpos + 4'd1);
                if (n_hpos == HDR_BYTES) begin
                    n_done = (n_cnt == 16'd0);
                end
            end else if (!r_done) begin
                if (r_upos == 4'd0) begin
                    n_level = i_byte;
                    n_value = '0;
                    n_vol   = '0;
                end else if (r_upos == 4'd1) begin
                    n_side = i_byte;
                end else if (r_upos < 4'd10) begin
                    n_value[8*v_off[2:0] +: 8] = i_byte;
                end else begin
                    n_vol[8*v_voff[1:0] +: 8] = i_byte;   // 10..13 -> lanes 0..3
                end
                if (r_upos == UPD_LAST) begin
                    n_upos       = '0;
                    n_wr.en      = (r_level == 8'd0) && (r_subj < 32'(SUBJECTS))
                                   && (r_side == SIDE_DEMAND || r_side == SIDE_SUPPLY);
                    n_wr.supply  = (r_side == SIDE_SUPPLY);
                    n_wr.addr    = r_subj[ADDR_W-1:0];
                    n_wr.value   = r_value;
                    n_wr.volume  = {i_byte, r_vol[23:0]};
                    n_cnt        = 16'(r_cnt - 16'd1);
                    if (n_cnt == 16'd0) begin
                        n_done = 1'b1;
                    end
                end else begin
                    n_upos = 4'(r_upos + 4'd1);
                end
            end
            if (i_last) begin
                n_end.en         = 1'b1;
                n_end.has_result = (n_hpos >= HDR_BYTES);
                n_end.subject    = n_subj;
                n_hpos = '0; n_upos = '0; n_subj = '0; n_cnt = '0;
                n_level = '0; n_side = '0; n_value = '0; n_vol = '0;
                n_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpos <= '0; r_upos <= '0; r_subj <= '0; r_cnt <= '0;
            r_level <= '0; r_side <= '0; r_value <= '0; r_vol <= '0;
            r_done <= 1'b0;
            r_wr <= '0;
            r_end <= '0;
        end else begin
            r_hpos <= n_hpos; r_upos <= n_upos; r_subj <= n_subj; r_cnt <= n_cnt;
            r_level <= n_level; r_side <= n_side; r_value <= n_value; r_vol <= n_vol;
            r_done <= n_done;
            r_wr <= n_wr;
            r_end <= n_end;
        end
    end

    assign o_wr  = r_wr;
    assign o_end = r_end;
endmodule

FILE: rtl/core/bwm_calc.sv
// Weighted cross price: 32x32 partial-product multiply, then restoring divide.
// Depends on bwm_pkg.
module bwm_calc import bwm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_zero,
    input  logic [63:0]        i_dm_value,
    input  logic [31:0]        i_dm_volume,
    input  logic [63:0]        i_sp_value,
    input  logic [31:0]        i_sp_volume,
    output logic               o_done,
    output logic signed [63:0] o_score
);
    t_calc_state         r_state, n_state;
    logic [63:0]         r_mag [2];
    logic                r_sgn [2];
    logic [31:0]         r_vol [2];
    logic [DEN_W-1:0]    r_den;
    logic [2:0]          r_step;
    logic [63:0]         r_prod;
    logic                r_pneg, r_psh, r_pvld;
    logic [ACC_W-1:0]    r_acc;
    logic [NUM_W-1:0]    r_nq;
    logic [REM_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                r_neg;
    logic [DEN_W-1:0]    v_den;
    logic [95:0]         v_term;
    logic [ACC_W-1:0]    v_sterm;
    logic [ACC_W-1:0]    v_mag;
    logic [REM_W-1:0]    v_trial;
    logic                v_qbit;
    logic [31:0]         v_half;

    assign v_den   = DEN_W'(i_dm_volume) + DEN_W'(i_sp_volume);
    assign v_term  = r_psh ? {r_prod, 32'd0} : {32'd0, r_prod};
    assign v_sterm = r_pneg ? ACC_W'(-{2'b00, v_term}) : {2'b00, v_term};
    assign v_mag   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
    assign v_trial = {r_rem[REM_W-2:0], r_nq[NUM_W-1]};
    assign v_qbit  = (v_trial >= REM_W'(r_den));
    assign v_half  = r_step[0] ? r_mag[r_step[1]][63:32] : r_mag[r_step[1]][31:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE:  if (i_start) begin
                n_state = (i_zero || v_den == '0) ? C_DONE : C_MUL;
            end
            C_MUL:   if (r_step == 3'd4) begin
                n_state = C_PREP;
            end
            C_PREP:  n_state = C_DIV;
            C_DIV:   if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                n_state = C_DONE;
            end
            C_DONE:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_pvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pvld  <= (r_state == C_MUL) && (r_step != 3'd4);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_mag[0] <= i_dm_value[63] ? 64'(-i_dm_value) : i_dm_value;
                r_sgn[0] <= i_dm_value[63];
                r_vol[0] <= i_sp_volume;
                r_mag[1] <= i_sp_value[63] ? 64'(-i_sp_value) : i_sp_value;
                r_sgn[1] <= i_sp_value[63];
                r_vol[1] <= i_dm_volume;
                r_den    <= v_den;
                r_step   <= '0;
                r_acc    <= '0;
                r_nq     <= '0;
                r_neg    <= 1'b0;
            end
            C_MUL: begin
                if (r_step != 3'd4) begin
                    r_prod <= 64'(v_half) * 64'(r_vol[r_step[1]]);
                    r_pneg <= r_sgn[r_step[1]];
                    r_psh  <= r_step[0];
                    r_step <= 3'(r_step + 3'd1);
                end
                if (r_pvld) begin
                    r_acc <= ACC_W'(r_acc + v_sterm);
                end
            end
            C_PREP: begin
                r_nq  <= v_mag[NUM_W-1:0];
                r_neg <= r_acc[ACC_W-1];
                r_rem <= '0;
                r_cnt <= '0;
            end
            C_DIV: begin
                r_rem <= v_qbit ? REM_W'(v_trial - REM_W'(r_den)) : v_trial;
                r_nq  <= {r_nq[NUM_W-2:0], v_qbit};
                r_cnt <= DIV_CNT_W'(r_cnt + 1'b1);
            end
            default: ;
        endcase
    end

    assign o_done  = (r_state == C_DONE);
    assign o_score = r_neg ? 64'(-r_nq[63:0]) : r_nq[63:0];
endmodule

FILE: rtl/core/book_update_weighted_mid_unit.sv
// Top level of the weighted-mid book unit.
// Depends on bwm_pkg, bwm_ifs, bwm_ram, bwm_parse, bwm_calc.
//
// Takes a message one byte per transaction (last_byte marks its end), keeps the
// level-0 demand and supply entry of each subject in two 1024 x 96 RAMs, and at
// the end of every message of ten or more bytes returns one result transaction:
// (Pd*Vs + Ps*Vd) / (Vd + Vs), truncated toward zero, or 0 when the volume sum
// is zero or the subject lies outside the table. After reset the block clears
// all 1024 entries of both RAMs, one entry per cycle, before it takes any byte.
// Inside a message one byte is taken per cycle. After the last byte the input
// stalls until the result is taken, through write settle, RAM read, operand
// load, a multiply-accumulate over four 32x32 partial products, a prep step, a
// one-bit-per-cycle divide over 97 numerator bits, a done state and the output
// state. A zero volume sum or an out-of-table subject skips the multiply, prep
// and divide. A message too short to give a result stalls only for write settle.
module book_update_weighted_mid_unit import bwm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bwm_in_if.sink           i_in,
    bwm_out_if.source        o_out
);
    t_top_state         r_state, n_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [31:0]        r_subj;
    logic               r_oot;
    logic [31:0]        r_out_subj;
    logic signed [63:0] r_out_score;
    logic               r_out_oot;
    logic               v_accept;
    t_wr_req            v_wr;
    t_msg_end           v_end;
    logic               v_clear;
    logic               v_dm_we, v_sp_we;
    logic [ADDR_W-1:0]  v_waddr;
    logic [ENTRY_W-1:0] v_wdata;
    logic [ENTRY_W-1:0] v_dm_rd, v_sp_rd;
    logic               v_calc_done;
    logic signed [63:0] v_calc_score;

    assign i_in.ready = (r_state == S_IDLE);
    assign v_accept   = i_in.valid && i_in.ready;

    bwm_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (v_accept),
        .i_byte   (i_in.msg_byte),
        .i_last   (i_in.last_byte),
        .o_wr     (v_wr),
        .o_end    (v_end)
    );

    // Clear sweep owns the write port until done; parser writes otherwise.
    assign v_clear = (r_state == S_CLEAR);
    assign v_dm_we = v_clear || (v_wr.en && !v_wr.supply);
    assign v_sp_we = v_clear || (v_wr.en && v_wr.supply);
    assign v_waddr = v_clear ? r_clr : v_wr.addr;
    assign v_wdata = v_clear ? '0 : {v_wr.value, v_wr.volume};

    bwm_ram #(.WIDTH(ENTRY_W), .DEPTH(SUBJECTS)) u_dm_ram (
        .i_clk   (i_clk),
        .i_we    (v_dm_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (r_subj[ADDR_W-1:0]),
        .o_rdata (v_dm_rd)
    );

    bwm_ram #(.WIDTH(ENTRY_W), .DEPTH(SUBJECTS)) u_sp_ram (
        .i_clk   (i_clk),
        .i_we    (v_sp_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (r_subj[ADDR_W-1:0]),
        .o_rdata (v_sp_rd)
    );

    bwm_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_LOAD),
        .i_zero      (r_oot),
        .i_dm_value  (v_dm_rd[95:32]),
        .i_dm_volume (v_dm_rd[31:0]),
        .i_sp_value  (v_sp_rd[95:32]),
        .i_sp_volume (v_sp_rd[31:0]),
        .o_done      (v_calc_done),
        .o_score     (v_calc_score)
    );

    // S_WAIT covers the cycle in which a final update is still being written,
    // so the read in S_READ sees it.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == ADDR_W'(SUBJECTS - 1)) begin
                n_state = S_IDLE;
            end
            S_IDLE:  if (v_accept && i_in.last_byte) begin
                n_state = S_WAIT;
            end
            S_WAIT:  n_state = v_end.has_result ? S_READ : S_IDLE;
            S_READ:  n_state = S_LOAD;
            S_LOAD:  n_state = S_CALC;
            S_CALC:  if (v_calc_done) begin
                n_state = S_OUT;
            end
            S_OUT:   if (o_out.ready) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (v_clear) begin
                r_clr <= ADDR_W'(r_clr + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT) begin
            r_subj <= v_end.subject;
            r_oot  <= !(v_end.subject < 32'(SUBJECTS));
        end
        if (r_state == S_CALC && v_calc_done) begin
            r_out_subj  <= r_subj;
            r_out_score <= v_calc_score;
            r_out_oot   <= r_oot;
        end
    end

    assign o_out.valid                = (r_state == S_OUT);
    assign o_out.subject_number       = r_out_subj;
    assign o_out.weighted_score       = r_out_score;
    assign o_out.subject_out_of_table = r_out_oot;
endmodule

FILE: rtl/core/bwm_check.sv
// Port-level checker for book_update_weighted_mid_unit, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bwm_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_score,
    input logic        i_out_oot
);
    `BWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `BWM_ASSERT_NOW(a_oot_zero, i_clk, i_rst_n, i_out_valid && i_out_oot, i_out_score == 64'd0, "out-of-table score not zero")
    `BWM_ASSERT_NEXT(a_last_stall, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready, "input taken right after last byte")
    `BWM_ASSERT_NOW(a_one_side, i_clk, i_rst_n, i_out_valid, !i_in_ready, "input open while result pending")
endmodule

bind book_update_weighted_mid_unit bwm_check u_bwm_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_score (o_out.weighted_score),
    .i_out_oot   (o_out.subject_out_of_table)
);
